@@ rtl/hba_pkg.sv @@
// shared constants, codes and helpers for the hierarchical bitmap allocator
package hba_pkg;

    localparam int WORD_BITS  = 32;
    localparam int NUM_LEAVES = 32;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int LEAF_W     = $clog2(NUM_LEAVES);
    localparam int SLOTS      = NUM_LEAVES * WORD_BITS;

    localparam int REQ_W  = 2;
    localparam int SLOT_W = 11;
    localparam int IDX_W  = 10;
    localparam int ST_W   = 2;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic commit;
    } hba_cmd_t;

    // priority encoder: index of the lowest clear bit
    function automatic logic [BIT_W-1:0] find_first_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/hba_req_if.sv @@
// request channel: request type and slot index
interface hba_req_if;
    logic                       valid;
    logic                       ready;
    logic [hba_pkg::REQ_W-1:0]  req_type;
    logic [hba_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, output req_type, output slot_index, input ready);
    modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface

@@ rtl/hba_rsp_if.sv @@
// response channel: result index and status
interface hba_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [hba_pkg::IDX_W-1:0] result_index;
    logic [hba_pkg::ST_W-1:0]  status;

    modport source (output valid, output result_index, output status, input ready);
    modport sink   (input valid, input result_index, input status, output ready);
endinterface

@@ rtl/hba_ctrl.sv @@
// control state machine: request and response handshakes, datapath commands
module hba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hba_pkg::hba_cmd_t cmd
);
    import hba_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        // leaf word is back; finish once the output register is free
        cmd.commit = (state_reg == S_READ) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/hba_datapath.sv @@
// datapath: full summary, leaf word memory, bit search and result register
module hba_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hba_pkg::hba_cmd_t          cmd,
    input  logic [hba_pkg::REQ_W-1:0]  req_type,
    input  logic [hba_pkg::SLOT_W-1:0] slot_index,
    output logic [hba_pkg::IDX_W-1:0]  result_index,
    output logic [hba_pkg::ST_W-1:0]   status
);
    import hba_pkg::*;

    logic [WORD_BITS-1:0]  leaf_mem [NUM_LEAVES];
    logic [NUM_LEAVES-1:0] leaf_valid_reg;
    logic [NUM_LEAVES-1:0] summary_reg;

    logic [REQ_W-1:0]     req_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [LEAF_W-1:0]    leaf_reg, leaf_next;
    logic [ST_W-1:0]      err_reg, err_next;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic [IDX_W-1:0]     res_index_reg, res_index_next;
    logic [ST_W-1:0]      res_status_reg;

    logic [WORD_BITS-1:0] word, onehot, new_word;
    logic [BIT_W-1:0]     bit_sel;
    logic                 is_alloc, wr_en;

    // decode at the request beat
    always_comb
    begin
        if (req_type == REQ_ALLOC)
        begin
            leaf_next = find_first_zero(summary_reg);
            err_next  = (&summary_reg) ? ST_FULL : ST_OK;
        end
        else
        begin
            leaf_next = slot_index[IDX_W-1:BIT_W];
            if ((req_type == REQ_FREE || req_type == REQ_MARK) &&
                (slot_index < SLOT_W'(SLOTS)))
            begin
                err_next = ST_OK;
            end
            else
            begin
                err_next = ST_RANGE;
            end
        end
    end

    // update of the chosen leaf word
    always_comb
    begin
        is_alloc = (req_reg == REQ_ALLOC);
        word     = rvalid_reg ? rdata_reg : '0;
        bit_sel  = is_alloc ? find_first_zero(word) : slot_reg[BIT_W-1:0];
        onehot   = WORD_BITS'(1) << bit_sel;
        new_word = (req_reg == REQ_FREE) ? (word & ~onehot) : (word | onehot);
        wr_en    = cmd.commit && (err_reg == ST_OK);
        if (err_reg != ST_OK)
        begin
            res_index_next = '0;
        end
        else if (is_alloc)
        begin
            res_index_next = {leaf_reg, bit_sel};
        end
        else
        begin
            res_index_next = slot_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            slot_reg  <= slot_index;
            leaf_reg  <= leaf_next;
            err_reg   <= err_next;
            rdata_reg <= leaf_mem[leaf_next];
        end
        if (wr_en)
        begin
            leaf_mem[leaf_reg] <= new_word;
        end
        if (cmd.commit)
        begin
            res_index_reg  <= res_index_next;
            res_status_reg <= err_reg;
        end
    end

    // never-written leaves read as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_valid_reg <= '0;
            summary_reg    <= '0;
            rvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rvalid_reg <= leaf_valid_reg[leaf_next];
            end
            if (wr_en)
            begin
                leaf_valid_reg[leaf_reg] <= 1'b1;
                summary_reg[leaf_reg]    <= &new_word;
            end
        end
    end

    assign result_index = res_index_reg;
    assign status       = res_status_reg;

endmodule

@@ rtl/hierarchical_bitmap_allocator_core.sv @@
// top level of the hierarchical bitmap slot allocator
//
// manages 1024 slots as 32 leaf words of 32 used bits plus a 32-bit summary
// that marks full leaf words. one request beat on req asks to allocate the
// lowest free slot, free a slot or mark a slot used; exactly one response
// beat on rsp follows with the slot index and a status (ok, full, range).
// a failed request leaves every slot as it was and returns index zero.
// one request is in flight at a time: a new request is taken only after
// the last one has written its response into the output register.
// the request beat reads the leaf word chosen by the summary search (or by
// the slot index) into a register; the commit step then does the bit search,
// writes the leaf word back and updates its summary bit.
// req.ready is high while no request is in flight, even if a response still
// waits in the output register. when rsp stalls, the next request's leaf
// word is read and then held until the output register frees up.
// after reset every slot is free; leaf words never written read as zero, so
// no clearing pass is needed.
module hierarchical_bitmap_allocator_core (
    input logic       clk,
    input logic       rst_n,
    hba_req_if.sink   req,
    hba_rsp_if.source rsp
);
    import hba_pkg::*;

    hba_cmd_t cmd;

    hba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    hba_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .slot_index   (req.slot_index),
        .result_index (rsp.result_index),
        .status       (rsp.status)
    );

endmodule

@@ rtl/hba_checker.sv @@
// port-level assertions for the allocator core and their bind
module hba_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [hba_pkg::IDX_W-1:0]  result_index,
    input logic [hba_pkg::ST_W-1:0]   status
);
    import hba_pkg::*;

    // a stalled response beat stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // one request in flight: ready drops after each request beat
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
        else $error("undefined status code");

    // failed requests report index zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |-> result_index == '0)
        else $error("nonzero index on failed request");

endmodule

bind hierarchical_bitmap_allocator_core hba_checker u_hba_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .result_index (rsp.result_index),
    .status       (rsp.status)
);
